>>> sv/fsc_pkg.sv
// ---------------------------------------------------------------------------
// fsc_pkg: shared constants for the floppy sector controller
// Opcodes, medium command codes, interrupt bits and default sizes.
// ---------------------------------------------------------------------------
package fsc_pkg;

  localparam int unsigned SectorBytes     = 128;
  localparam int unsigned SectorsPerTrack = 26;
  localparam int unsigned LastTrack       = 73;
  localparam int unsigned Drives          = 4;

  localparam logic [3:0] OpRead      = 4'd0;
  localparam logic [3:0] OpCheck     = 4'd1;
  localparam logic [3:0] OpReset     = 4'd2;
  localparam logic [3:0] OpDetach    = 4'd3;
  localparam logic [3:0] OpWrite     = 4'd4;
  localparam logic [3:0] OpControl   = 4'd5;
  localparam logic [3:0] OpFill      = 4'd6;
  localparam logic [3:0] OpReadDone  = 4'd7;
  localparam logic [3:0] OpDrain     = 4'd8;
  localparam logic [3:0] OpWriteDone = 4'd9;
  localparam logic [3:0] OpIntSpec   = 4'd10;

  localparam logic [1:0] CmdNone  = 2'd0;
  localparam logic [1:0] CmdRead  = 2'd1;
  localparam logic [1:0] CmdWrite = 2'd2;

  localparam logic [5:0] IrqHw    = 6'h08;
  localparam logic [5:0] IrqEnd   = 6'h10;
  localparam logic [5:0] IrqReady = 6'h20;

  // spec code per interrupt bit, bit 0 first
  function automatic logic [4:0] spec_code(input logic [2:0] bit_idx);
    logic [4:0] c;
    c = 5'd0;
    case (bit_idx)
      3'd0: c = 5'b11010;
      3'd1: c = 5'b01010;
      3'd2: c = 5'b10010;
      3'd3: c = 5'b00010;
      3'd4: c = 5'b00100;
      3'd5: c = 5'b00001;
      default: c = 5'd0;
    endcase
    return c;
  endfunction

endpackage

>>> sv/fsc_ram.sv
// ---------------------------------------------------------------------------
// fsc_ram: generic single-port RAM
// One write or read per cycle, read data registered.
// ---------------------------------------------------------------------------
module fsc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> sv/floppy_sector_controller_unit.sv
// ---------------------------------------------------------------------------
// floppy_sector_controller_unit: sector-buffered floppy controller
// One command or medium event word in, one status/result word out.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one word per command or medium event (op, data, index,
//   byte). m_axis returns exactly one result word per input word.
//   drive_attached_we_i/drive_attached_i write the medium-present mask.
// Timing:
//   Each word is accepted, decoded, then its result registered. A buffer
//   read or a drain adds a registered RAM read before the result. A detach
//   during buffer fill zero-pads the rest of the sector buffer one byte per
//   cycle; the single-port sector buffer sets this rate. One word is in
//   flight at a time; s_axis_tready is low while working or while a result
//   waits.
// Reset:
//   Address goes to drive 0, track 1, sector 1; interrupts cleared; buffer
//   contents undefined until written.
// Stall:
//   The result is held in the output register until m_axis_tready is high.
// ---------------------------------------------------------------------------
module floppy_sector_controller_unit #(
  parameter int unsigned SectorBytes     = fsc_pkg::SectorBytes,
  parameter int unsigned SectorsPerTrack = fsc_pkg::SectorsPerTrack,
  parameter int unsigned LastTrack       = fsc_pkg::LastTrack,
  parameter int unsigned Drives          = fsc_pkg::Drives
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        drive_attached_we_i,
  input  logic [3:0]  drive_attached_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: op[3:0], data_word[19:4], buf_index[26:20], medium_byte[34:27], pad
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: io_status[0], read_data[8:1], medium_cmd[10:9], medium_drive[12:11],
  //        medium_sector_index[23:13], drain_byte[31:24], irq_pending[32],
  //        int_spec[37:33], pad
  output logic [39:0] m_axis_tdata
);

  localparam int unsigned AW = $clog2(SectorBytes);
  localparam int unsigned PW = AW + 1;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSectRd = 3'd1;
  localparam logic [2:0] StBufRd  = 3'd2;
  localparam logic [2:0] StBufWr  = 3'd3;
  localparam logic [2:0] StSectWr = 3'd4;

  // sequencer phases
  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhMem  = 2'd1;
  localparam logic [1:0] PhPad  = 2'd2;
  localparam logic [1:0] PhOut  = 2'd3;

  logic [1:0]  ph_q, ph_d;
  logic [2:0]  st_q, st_d;
  logic [1:0]  drv_q, drv_d;
  logic        side_q, side_d;
  logic [6:0]  trk_q, trk_d;
  logic [4:0]  sec_q, sec_d;
  logic [PW-1:0] pos_q, pos_d;
  logic        wpend_q, wpend_d, fready_q, fready_d, endf_q, endf_d;
  logic [5:0]  irq_q, irq_d;
  logic [3:0]  att_q;

  logic [3:0]  op_q;
  logic [15:0] dw_q;
  logic [6:0]  bi_q;
  logic [7:0]  mb_q;
  logic        mem_rd_q, mem_rd_d, mem_drain_q, mem_drain_d;

  logic        ost_q, ost_d;
  logic [7:0]  ord_q, ord_d, odr_q, odr_d;
  logic [1:0]  ocmd_q, ocmd_d, odrv_q, odrv_d;
  logic [10:0] oidx_q, oidx_d;
  logic [4:0]  ospec_q, ospec_d;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;

  fsc_ram #(.Width(8), .Depth(SectorBytes)) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // input ready only when idle; result valid in PhOut once a pending buffer read has landed
  assign s_axis_tready = (ph_q == PhIdle);
  assign m_axis_tvalid = (ph_q == PhOut) && !mem_rd_q && !mem_drain_q;
  assign m_axis_tdata  = {2'b0, ospec_q, (irq_q != 6'd0), odr_q, oidx_q, odrv_q,
                          ocmd_q, ord_q, ost_q};

  // capture the input word
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q <= s_axis_tdata[3:0];
      dw_q <= s_axis_tdata[19:4];
      bi_q <= s_axis_tdata[26:20];
      mb_q <= s_axis_tdata[34:27];
    end
  end

  // helper values
  logic        present, disk_end, idx_ok;
  logic [10:0] lin_idx;
  logic [5:0]  ready_bits;
  always_comb begin
    present    = (32'(drv_q) < Drives) && att_q[drv_q];
    disk_end   = (32'(sec_q) == SectorsPerTrack) && (32'(trk_q) == LastTrack);
    idx_ok     = 32'(bi_q) < SectorBytes;
    lin_idx    = 11'(32'(trk_q) * SectorsPerTrack + 32'(sec_q) - 32'd1);
    ready_bits = fsc_pkg::IrqReady | (disk_end ? fsc_pkg::IrqEnd : 6'd0);
  end

  // main sequencer: decode in PhMem, zero-pad in PhPad, buffer data arrives in PhOut entry
  always_comb begin
    logic [5:0] sn;
    logic [7:0] tn;
    ph_d = ph_q; st_d = st_q; drv_d = drv_q; side_d = side_q; trk_d = trk_q;
    sec_d = sec_q; pos_d = pos_q; wpend_d = wpend_q; fready_d = fready_q;
    endf_d = endf_q; irq_d = irq_q;
    mem_rd_d = 1'b0; mem_drain_d = 1'b0;
    ost_d = ost_q; ord_d = ord_q; odr_d = odr_q; ocmd_d = ocmd_q;
    odrv_d = odrv_q; oidx_d = oidx_q; ospec_d = ospec_q;
    ram_we = 1'b0; ram_addr = pos_q[AW-1:0]; ram_wdata = 8'd0;
    sn = {1'b0, sec_q} + 6'd1; tn = {1'b0, trk_q};
    unique case (ph_q)
      PhIdle: begin
        if (s_axis_tvalid) ph_d = PhMem;
      end
      PhMem: begin
        ph_d = PhOut;
        ost_d = 1'b1; ord_d = 8'd0; odr_d = 8'd0; ocmd_d = fsc_pkg::CmdNone;
        odrv_d = 2'd0; oidx_d = 11'd0; ospec_d = 5'd0;
        case (op_q)
          fsc_pkg::OpRead: begin
            if (st_q == StIdle) begin
              if (!present) begin
                irq_d = fsc_pkg::IrqHw; fready_d = 1'b0;
              end else begin
                st_d = StSectRd; ocmd_d = fsc_pkg::CmdRead;
                odrv_d = drv_q; oidx_d = lin_idx;
              end
            end else if (st_q == StBufRd) begin
              mem_rd_d = 1'b1; ost_d = 1'b0; irq_d = 6'd0;
              pos_d = pos_q + PW'(1);
              if (32'(pos_d) >= SectorBytes) st_d = StIdle;
            end
          end
          fsc_pkg::OpCheck: ost_d = 1'b0;
          fsc_pkg::OpReset: begin
            st_d = StIdle; drv_d = 2'd0; side_d = 1'b0; trk_d = 7'd1;
            sec_d = 5'd1; pos_d = '0; wpend_d = 1'b0; fready_d = 1'b0;
            irq_d = 6'd0; ost_d = 1'b0;
          end
          fsc_pkg::OpDetach: begin
            if (st_q == StIdle) begin
              irq_d = 6'd0; ost_d = 1'b0;
            end else if (st_q == StBufRd) begin
              pos_d = '0; irq_d = fsc_pkg::IrqReady; fready_d = 1'b0; st_d = StIdle;
            end else if (st_q == StBufWr) begin
              ph_d = PhPad; st_d = StSectWr; fready_d = 1'b1;
              ocmd_d = fsc_pkg::CmdWrite; odrv_d = drv_q; oidx_d = lin_idx;
            end else if (st_q == StSectWr) begin
              fready_d = 1'b1; wpend_d = 1'b0;
            end
          end
          fsc_pkg::OpWrite: begin
            if (st_q == StIdle) begin
              if (!present) begin
                irq_d = fsc_pkg::IrqHw;
              end else begin
                irq_d = ready_bits; st_d = StBufWr; pos_d = '0;
              end
              fready_d = 1'b0;
            end else if (st_q == StBufWr) begin
              ram_we = 1'b1; ram_wdata = dw_q[7:0];
              pos_d = pos_q + PW'(1); irq_d = 6'd0; ost_d = 1'b0;
              if (32'(pos_d) >= SectorBytes) begin
                st_d = StSectWr; ocmd_d = fsc_pkg::CmdWrite;
                odrv_d = drv_q; oidx_d = lin_idx;
              end
            end else if (st_q == StSectWr) begin
              wpend_d = 1'b1;
            end
          end
          fsc_pkg::OpControl: begin
            if (st_q == StIdle) begin
              drv_d = {dw_q[15], dw_q[13]}; side_d = dw_q[12];
              trk_d = dw_q[11:5]; sec_d = dw_q[4:0]; pos_d = '0; ost_d = 1'b0;
            end
          end
          fsc_pkg::OpFill: begin
            if (st_q == StSectRd && idx_ok) begin
              ram_we = 1'b1; ram_addr = bi_q[AW-1:0]; ram_wdata = mb_q;
              ost_d = 1'b0;
            end
          end
          fsc_pkg::OpReadDone: begin
            if (st_q == StSectRd) begin
              irq_d = ready_bits; fready_d = 1'b0; pos_d = '0;
              st_d = StBufRd; ost_d = 1'b0;
            end
          end
          fsc_pkg::OpDrain: begin
            if (st_q == StSectWr && idx_ok) begin
              ram_addr = bi_q[AW-1:0]; mem_drain_d = 1'b1; ost_d = 1'b0;
            end
          end
          fsc_pkg::OpWriteDone: begin
            if (st_q == StSectWr) begin
              pos_d = '0; ost_d = 1'b0;
              if (fready_q) begin
                irq_d = fsc_pkg::IrqReady; fready_d = 1'b0;
              end
              st_d = StIdle;
            end
          end
          fsc_pkg::OpIntSpec: begin
            ost_d = 1'b0;
            for (int i = 5; i >= 0; i--) begin
              if (irq_q[i]) begin
                ospec_d = fsc_pkg::spec_code(3'(i));
                irq_d = irq_q & ~(6'd1 << i);
              end
            end
          end
          default: ost_d = 1'b0;
        endcase
        // address advance: end of buffer read, detach in buffer read,
        // write done; a pending write then restarts with the new address
        if ((op_q == fsc_pkg::OpRead && st_q == StBufRd && 32'(pos_d) >= SectorBytes)
            || (op_q == fsc_pkg::OpDetach && st_q == StBufRd)
            || (op_q == fsc_pkg::OpWriteDone && st_q == StSectWr)) begin
          pos_d = '0;
          if (32'(sn) > SectorsPerTrack) begin
            sn = 6'd1; tn = {1'b0, trk_q} + 8'd1;
            if (32'(tn) > LastTrack) begin
              tn = 8'd1; endf_d = 1'b1;
            end
          end
          sec_d = sn[4:0]; trk_d = tn[6:0];
          if (op_q == fsc_pkg::OpWriteDone && wpend_q) begin
            wpend_d = 1'b0; fready_d = 1'b0;
            if (!(32'(drv_q) < Drives && att_q[drv_q])) begin
              irq_d = fsc_pkg::IrqHw;
            end else begin
              irq_d = fsc_pkg::IrqReady |
                      ((32'(sn) == SectorsPerTrack && 32'(tn) == LastTrack)
                       ? fsc_pkg::IrqEnd : 6'd0);
              st_d = StBufWr;
            end
          end
        end
      end
      PhPad: begin
        // zero-fill the rest of the buffer, one byte per cycle
        if (32'(pos_q) < SectorBytes) begin
          ram_we = 1'b1; pos_d = pos_q + PW'(1);
        end else begin
          ph_d = PhOut;
        end
      end
      PhOut: begin
        if (mem_rd_q)    ord_d = ram_rdata;
        if (mem_drain_q) odr_d = ram_rdata;
        if (m_axis_tready && !mem_rd_q && !mem_drain_q) ph_d = PhIdle;
      end
      default: ph_d = PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhIdle; st_q <= StIdle; drv_q <= 2'd0; side_q <= 1'b0;
      trk_q <= 7'd1; sec_q <= 5'd1; pos_q <= '0; wpend_q <= 1'b0;
      fready_q <= 1'b0; endf_q <= 1'b0; irq_q <= 6'd0; att_q <= 4'd0;
      mem_rd_q <= 1'b0; mem_drain_q <= 1'b0;
    end else begin
      ph_q <= ph_d; st_q <= st_d; drv_q <= drv_d; side_q <= side_d;
      trk_q <= trk_d; sec_q <= sec_d; pos_q <= pos_d; wpend_q <= wpend_d;
      fready_q <= fready_d; endf_q <= endf_d; irq_q <= irq_d;
      mem_rd_q <= mem_rd_d; mem_drain_q <= mem_drain_d;
      if (drive_attached_we_i) att_q <= drive_attached_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ost_q <= ost_d; ord_q <= ord_d; odr_q <= odr_d; ocmd_q <= ocmd_d;
    odrv_q <= odrv_d; oidx_q <= oidx_d; ospec_q <= ospec_d;
  end

`ifndef ASSERT_OFF
  // result stays valid while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && !mem_rd_q && !mem_drain_q |=> m_axis_tvalid)
    else $error("result dropped while stalled");
  // no input taken while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted with result pending");
  // buffer position never passes the sector size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) <= SectorBytes)
    else $error("byte position out of range");
  // padding only happens in the sector write state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == PhPad |-> st_q == StSectWr)
    else $error("padding outside sector write");
`endif

endmodule

>>> dv/fsc_checker.sv
// ---------------------------------------------------------------------------
// fsc_checker: result predictor and scoreboard for the floppy controller
// Watches the command and result streams. Each accepted command word is run
// through a behavioral copy of the controller, and the predicted result is
// compared field by field with the next result word.
// ---------------------------------------------------------------------------
module fsc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        drive_attached_we_i,
  input  logic [3:0]  drive_attached_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    StIdle, StSectRd, StBufRd, StBufWr, StSectWr
  } ctl_state_e;

  typedef struct packed {
    logic       status;
    logic [7:0] rd_byte;
    logic [1:0] cmd;
    logic [1:0] drive;
    logic [10:0] sect_idx;
    logic [7:0] drain;
    logic       irq;
    logic [4:0] spec;
  } fsc_result_t;

  // shadow controller state
  ctl_state_e  mode;
  logic [3:0]  attached;
  logic [1:0]  drive;
  int          track, sector, pos;
  logic [7:0]  sbuf [fsc_pkg::SectorBytes];
  logic        wr_pending, force_rdy;
  logic [5:0]  irqs;

  fsc_result_t expected_q[$];
  int          mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = expected_q.size();

  function automatic logic [4:0] irq_spec(input int b);
    case (b)
      0: return 5'b11010;
      1: return 5'b01010;
      2: return 5'b10010;
      3: return 5'b00010;
      4: return 5'b00100;
      default: return 5'b00001;
    endcase
  endfunction

  function automatic logic at_end();
    return sector == int'(fsc_pkg::SectorsPerTrack) && track == int'(fsc_pkg::LastTrack);
  endfunction

  task automatic post(input logic [5:0] bits);
    irqs = bits;
    force_rdy = 1'b0;
  endtask

  task automatic advance_addr();
    sector++;
    pos = 0;
    if (sector > int'(fsc_pkg::SectorsPerTrack)) begin
      sector = 1;
      track++;
      if (track > int'(fsc_pkg::LastTrack)) track = 1;
    end
  endtask

  task automatic issue(inout fsc_result_t r, input logic [1:0] c);
    int lin;
    lin = track * int'(fsc_pkg::SectorsPerTrack) + sector - 1;
    r.cmd = c;
    r.drive = drive;
    r.sect_idx = lin[10:0];
  endtask

  task automatic start_write();
    if (!attached[drive]) begin
      post(fsc_pkg::IrqHw);
      mode = StIdle;
    end else begin
      post(fsc_pkg::IrqReady | (at_end() ? fsc_pkg::IrqEnd : 6'h0));
      mode = StBufWr;
      pos = 0;
    end
  endtask

  task automatic clear_ctl();
    mode = StIdle;
    drive = '0;
    track = 1;
    sector = 1;
    pos = 0;
    wr_pending = 1'b0;
    force_rdy = 1'b0;
    irqs = '0;
  endtask

  // compute the result word for one command word
  task automatic predict_result(input logic [39:0] w);
    fsc_result_t r;
    logic [3:0]  op;
    logic [15:0] dw;
    logic [6:0]  bidx;
    logic [7:0]  mb;
    op = w[3:0];
    dw = w[19:4];
    bidx = w[26:20];
    mb = w[34:27];
    r = '0;
    r.status = 1'b1;
    case (op)
      fsc_pkg::OpRead: begin
        if (mode == StIdle) begin
          if (!attached[drive]) post(fsc_pkg::IrqHw);
          else begin
            mode = StSectRd;
            issue(r, fsc_pkg::CmdRead);
          end
        end else if (mode == StBufRd && pos < int'(fsc_pkg::SectorBytes)) begin
          r.rd_byte = sbuf[pos];
          pos++;
          if (pos >= int'(fsc_pkg::SectorBytes)) begin
            advance_addr();
            mode = StIdle;
          end
          irqs = '0;
          r.status = 1'b0;
        end
      end
      fsc_pkg::OpCheck: r.status = 1'b0;
      fsc_pkg::OpReset: begin
        clear_ctl();
        r.status = 1'b0;
      end
      fsc_pkg::OpDetach: begin
        case (mode)
          StIdle: begin
            irqs = '0;
            r.status = 1'b0;
          end
          StBufRd: begin
            advance_addr();
            post(fsc_pkg::IrqReady);
            mode = StIdle;
          end
          StBufWr: begin
            while (pos < int'(fsc_pkg::SectorBytes)) begin
              sbuf[pos] = 8'h00;
              pos++;
            end
            mode = StSectWr;
            force_rdy = 1'b1;
            issue(r, fsc_pkg::CmdWrite);
          end
          StSectWr: begin
            force_rdy = 1'b1;
            wr_pending = 1'b0;
          end
          default: ;
        endcase
      end
      fsc_pkg::OpWrite: begin
        if (mode == StIdle) start_write();
        else if (mode == StBufWr && pos < int'(fsc_pkg::SectorBytes)) begin
          sbuf[pos] = dw[7:0];
          pos++;
          if (pos >= int'(fsc_pkg::SectorBytes)) begin
            mode = StSectWr;
            issue(r, fsc_pkg::CmdWrite);
          end
          irqs = '0;
          r.status = 1'b0;
        end else if (mode == StSectWr) wr_pending = 1'b1;
      end
      fsc_pkg::OpControl: begin
        if (mode == StIdle) begin
          drive = {dw[15], dw[13]};
          track = int'(dw[11:5]);
          sector = int'(dw[4:0]);
          pos = 0;
          r.status = 1'b0;
        end
      end
      fsc_pkg::OpFill: begin
        if (mode == StSectRd && 32'(bidx) < fsc_pkg::SectorBytes) begin
          sbuf[bidx] = mb;
          r.status = 1'b0;
        end
      end
      fsc_pkg::OpReadDone: begin
        if (mode == StSectRd) begin
          post(fsc_pkg::IrqReady | (at_end() ? fsc_pkg::IrqEnd : 6'h0));
          pos = 0;
          mode = StBufRd;
          r.status = 1'b0;
        end
      end
      fsc_pkg::OpDrain: begin
        if (mode == StSectWr && 32'(bidx) < fsc_pkg::SectorBytes) begin
          r.drain = sbuf[bidx];
          r.status = 1'b0;
        end
      end
      fsc_pkg::OpWriteDone: begin
        if (mode == StSectWr) begin
          advance_addr();
          if (force_rdy) post(fsc_pkg::IrqReady);
          if (wr_pending) begin
            wr_pending = 1'b0;
            start_write();
          end else mode = StIdle;
          r.status = 1'b0;
        end
      end
      fsc_pkg::OpIntSpec: begin
        for (int b = 0; b < 6; b++) begin
          if (irqs[b]) begin
            r.spec = irq_spec(b);
            irqs[b] = 1'b0;
            break;
          end
        end
        r.status = 1'b0;
      end
      default: r.status = 1'b0;
    endcase
    r.irq = |irqs;
    expected_q.push_back(r);
  endtask

  task automatic note_mismatch(input string what, input int exp_v, input int act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, exp_v, act_v);
  endtask

  // sample both streams at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    fsc_result_t e, a;
    if (!rst_ni) begin
      clear_ctl();
      attached = '0;
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (drive_attached_we_i) attached = drive_attached_i;
      if (s_axis_tvalid && s_axis_tready) predict_result(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        a.status = m_axis_tdata[0];
        a.rd_byte = m_axis_tdata[8:1];
        a.cmd = m_axis_tdata[10:9];
        a.drive = m_axis_tdata[12:11];
        a.sect_idx = m_axis_tdata[23:13];
        a.drain = m_axis_tdata[31:24];
        a.irq = m_axis_tdata[32];
        a.spec = m_axis_tdata[37:33];
        if (expected_q.size() == 0)
          note_mismatch("unexpected word", 0, int'(m_axis_tdata[31:0]));
        else begin
          e = expected_q.pop_front();
          if (a.status !== e.status)
            note_mismatch("io_status", int'(e.status), int'(a.status));
          if (a.rd_byte !== e.rd_byte)
            note_mismatch("read_data", int'(e.rd_byte), int'(a.rd_byte));
          if (a.cmd !== e.cmd) note_mismatch("medium_cmd", int'(e.cmd), int'(a.cmd));
          if (a.drive !== e.drive)
            note_mismatch("medium_drive", int'(e.drive), int'(a.drive));
          if (a.sect_idx !== e.sect_idx)
            note_mismatch("medium_sector_index", int'(e.sect_idx), int'(a.sect_idx));
          if (a.drain !== e.drain)
            note_mismatch("drain_byte", int'(e.drain), int'(a.drain));
          if (a.irq !== e.irq) note_mismatch("irq_pending", int'(e.irq), int'(a.irq));
          if (a.spec !== e.spec) note_mismatch("int_spec", int'(e.spec), int'(a.spec));
        end
      end
    end
  end

endmodule

>>> dv/tb_floppy_sector_controller_unit.sv
// ---------------------------------------------------------------------------
// tb_floppy_sector_controller_unit: stimulus and verdict
// Drives command and medium-event words: a directed opening, then random
// read and write sector sequences mixed with noise, over several
// drive-attached masks and backpressure profiles. The checker predicts.
// ---------------------------------------------------------------------------
module tb_floppy_sector_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1000000;
  localparam int SectBytes  = int'(fsc_pkg::SectorBytes);

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        drive_attached_we_i = 1'b0;
  logic [3:0]  drive_attached_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  int          fail_count, pending;
  int          words_sent = 0;
  int          cycles = 0;
  int          phase = 0;
  int          src_idle_pct = 21;
  int          snk_idle_pct = 72;

  floppy_sector_controller_unit i_dut (.*);

  fsc_checker i_checker (
    .clk_i, .rst_ni, .drive_attached_we_i, .drive_attached_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off when phase 3 opens
  always @(negedge clk_i) begin
    int hold, last_phase;
    if (phase == 3 && last_phase != 3) hold = 300;
    last_phase = phase;
    if (hold > 0) begin
      hold--;
      m_axis_tready = 1'b0;
    end else m_axis_tready = ($urandom_range(0, 99) >= snk_idle_pct);
  end

  task automatic send_word(input logic [3:0] op, input logic [15:0] dw = '0,
                           input logic [6:0] bidx = '0, input logic [7:0] mb = '0);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {5'b0, mb, bidx, dw, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
  endtask

  // wait for the controller to drain, then write the medium mask
  task automatic set_mask(input logic [3:0] mask);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SectBytes + 8) @(negedge clk_i);
    drive_attached_i = mask;
    drive_attached_we_i = 1'b1;
    @(negedge clk_i);
    drive_attached_we_i = 1'b0;
  endtask

  // address word: drive in bits 15 and 13, bit 14 is don't care
  function automatic logic [15:0] addr_word();
    logic [1:0] d;
    logic [6:0] trk;
    logic [4:0] sec;
    d = 2'($urandom);
    case ($urandom_range(0, 4))
      0: trk = 7'd1;
      1: trk = 7'(fsc_pkg::LastTrack);
      2: trk = 7'(fsc_pkg::LastTrack - 1);
      default: trk = 7'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: sec = 5'd1;
      1: sec = 5'(fsc_pkg::SectorsPerTrack);
      2: sec = 5'(fsc_pkg::SectorsPerTrack - 1);
      default: sec = 5'($urandom);
    endcase
    return {d[1], 1'($urandom), d[0], 1'($urandom), trk, sec};
  endfunction

  task automatic read_sequence();
    int n;
    send_word(fsc_pkg::OpControl, addr_word());
    send_word(fsc_pkg::OpRead, 16'($urandom));
    repeat ($urandom_range(0, 6))
      send_word(fsc_pkg::OpFill, 16'($urandom), 7'($urandom), 8'($urandom));
    send_word(fsc_pkg::OpReadDone);
    if ($urandom_range(0, 2) == 0) send_word(fsc_pkg::OpIntSpec);
    n = ($urandom_range(0, 9) == 0) ? SectBytes : int'($urandom_range(0, 8));
    repeat (n) send_word(fsc_pkg::OpRead, 16'($urandom));
    if (n < SectBytes) send_word(fsc_pkg::OpDetach);
    send_word(fsc_pkg::OpIntSpec);
  endtask

  task automatic write_sequence();
    int n;
    send_word(fsc_pkg::OpControl, addr_word());
    send_word(fsc_pkg::OpWrite, 16'($urandom));
    n = ($urandom_range(0, 9) == 0) ? SectBytes : int'($urandom_range(0, 8));
    repeat (n) send_word(fsc_pkg::OpWrite, 16'($urandom));
    if (n < SectBytes) send_word(fsc_pkg::OpDetach);
    repeat ($urandom_range(0, 4))
      send_word(fsc_pkg::OpDrain, 16'($urandom), 7'($urandom));
    if ($urandom_range(0, 2) == 0) send_word(fsc_pkg::OpWrite, 16'($urandom));
    if ($urandom_range(0, 3) == 0) send_word(fsc_pkg::OpDetach);
    send_word(fsc_pkg::OpWriteDone);
    if ($urandom_range(0, 1) == 0) send_word(fsc_pkg::OpWriteDone);
    repeat ($urandom_range(1, 2)) send_word(fsc_pkg::OpIntSpec);
  endtask

  task automatic random_phase(input int n_words);
    int stop_at;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: read_sequence();
        4, 5, 6: write_sequence();
        7: repeat ($urandom_range(1, 3)) send_word(fsc_pkg::OpIntSpec);
        default: repeat ($urandom_range(1, 4))
          send_word(4'($urandom), 16'($urandom), 7'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: fill the whole buffer first so later reads see defined bytes
    set_mask(4'hF);
    send_word(fsc_pkg::OpCheck);
    send_word(4'd15, 16'hFFFF, 7'h7F, 8'hFF);
    send_word(fsc_pkg::OpIntSpec);
    send_word(fsc_pkg::OpDetach);
    send_word(fsc_pkg::OpControl, {3'b000, 1'b1, 7'd73, 5'd26});
    send_word(fsc_pkg::OpWrite);
    for (int i = 0; i < SectBytes; i++)
      send_word(fsc_pkg::OpWrite,
                (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom));
    send_word(fsc_pkg::OpWrite);
    send_word(fsc_pkg::OpDrain, '0, 7'd0);
    send_word(fsc_pkg::OpDrain, '0, 7'h7F);
    send_word(fsc_pkg::OpReadDone);
    send_word(fsc_pkg::OpWriteDone);
    send_word(fsc_pkg::OpIntSpec);
    send_word(fsc_pkg::OpIntSpec);
    send_word(fsc_pkg::OpWrite, 16'h00A5);
    send_word(fsc_pkg::OpDetach);
    send_word(fsc_pkg::OpDetach);
    send_word(fsc_pkg::OpWriteDone);
    send_word(fsc_pkg::OpControl, 16'hFFFF);
    send_word(fsc_pkg::OpRead);
    send_word(fsc_pkg::OpFill, '0, 7'h7F, 8'hFF);
    send_word(fsc_pkg::OpReadDone);
    send_word(fsc_pkg::OpIntSpec);
    send_word(fsc_pkg::OpRead);
    send_word(fsc_pkg::OpDetach);
    send_word(fsc_pkg::OpReset);

    random_phase(200);
    phase = 1;
    src_idle_pct = 72;
    snk_idle_pct = 21;
    set_mask(4'h0);
    random_phase(50);
    phase = 2;
    set_mask(4'($urandom));
    random_phase(200);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_mask(4'h5);
    // long hold-off starts while the sender keeps offering words
    phase = 3;
    random_phase(200);

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SectBytes + 8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
